// File: rtl/assert_macros.svh
// Assertion macros used by the RTL files that check themselves (here the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mi4_pkg.sv
// Shared types, widths and index helpers for the 4x4 matrix inverse.
package mi4_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EW = 32;                 // element width
	localparam int CW = 100;                // cofactor accumulator width
	localparam int DW = 136;                // determinant width
	localparam int CEXT = 128;              // cofactor split into four 32-bit chunks
	localparam int QDEPTH = 2;              // queue depth between front and back
	localparam logic [3:0] LAST_IDX = 4'd15;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [3:0] idx;
		logic [31:0] val;
		logic last;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic start;
		logic neg;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] value;
		logic sat;
	} div_res_t;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
	} pair_t;

	// n-th member of {0,1,2,3} with x removed
	function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] n);
		logic [1:0] r;
		r = n + {1'b0, (n >= x)};
		return r;
	endfunction

	// Element addresses for cofactor k, expansion term, micro-op.
	// op 0: a*b, op 1: c*d, ops 2/3: outer element.
	function automatic pair_t cof_pair(input logic [3:0] k, input logic [1:0] term,
		input logic [1:0] op);
		pair_t r;
		logic [1:0] gx, rx, g0, g1, g2, q, s, rp;
		gx = k[1:0];
		rx = k[3:2];
		g0 = skip_idx(gx, 2'd0);
		g1 = skip_idx(gx, 2'd1);
		g2 = skip_idx(gx, 2'd2);
		q = (term == 2'd0) ? skip_idx(rx, 2'd1) : skip_idx(rx, 2'd0);
		s = (term == 2'd2) ? skip_idx(rx, 2'd1) : skip_idx(rx, 2'd2);
		rp = skip_idx(rx, term);
		unique case (op)
			2'd0: begin
				r.a = {g1, q};
				r.b = {g2, s};
			end
			2'd1: begin
				r.a = {g1, s};
				r.b = {g2, q};
			end
			default: begin
				r.a = {g0, rp};
				r.b = {g0, rp};
			end
		endcase
		return r;
	endfunction

endpackage

// File: rtl/mi4_front.sv
// Front end: takes items and queues them for the back end.
module mi4_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  mi4_pkg::item_t in_item,
	input  logic pop,
	output logic busy,
	output mi4_pkg::q_head_t head
);
	import mi4_pkg::*;

	item_t entry_q [QDEPTH];
	logic wr_q, rd_q;
	logic [1:0] count_q;
	logic push;

	assign busy = (count_q == 2'(QDEPTH));
	assign push = start && !busy;
	assign head.valid = (count_q != 2'd0);
	assign head.item = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= in_item;
	end

endmodule

// File: rtl/mi4_div.sv
// Sequential divider: 32-bit saturating quotient, one bit per cycle.
module mi4_div #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF,
	parameter int NUMW = mi4_pkg::CW + 2 * FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  mi4_pkg::div_req_t req,
	input  logic [NUMW-1:0] num,
	input  logic [mi4_pkg::DW-1:0] den,
	output mi4_pkg::div_res_t res
);
	import mi4_pkg::*;

	localparam int RW = (NUMW > DW + 32) ? NUMW : DW + 32;

	typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_FIN} dstate_t;

	dstate_t state_q;
	logic [RW-1:0] r_q, dsh_q;
	logic [31:0] q_q;
	logic [4:0] cnt_q;
	logic neg_q, sat_q;
	logic ge;
	logic [31:0] limit;
	logic over;

	assign ge = (r_q >= dsh_q);
	assign limit = neg_q ? Q_MIN : Q_MAX;
	assign over = sat_q || (q_q > limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q <= 5'd0;
			res <= '0;
		end else begin
			res.done <= 1'b0;
			unique case (state_q)
				D_IDLE: if (req.start) state_q <= D_CHECK;
				D_CHECK: begin
					cnt_q <= 5'd31;
					state_q <= ge ? D_FIN : D_RUN;
				end
				D_RUN: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= D_FIN;
				end
				D_FIN: begin
					res.done <= 1'b1;
					res.sat <= over;
					res.value <= over ? limit : (neg_q ? (32'd0 - q_q) : q_q);
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (req.start) begin
					r_q <= RW'(num);
					dsh_q <= RW'(den) << 32;
					neg_q <= req.neg;
					sat_q <= 1'b0;
					q_q <= '0;
				end
			end
			D_CHECK: begin
				if (ge) sat_q <= 1'b1;
				dsh_q <= dsh_q >> 1;
			end
			D_RUN: begin
				if (ge) r_q <= r_q - dsh_q;
				q_q <= {q_q[30:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/mi4_back.sv
// Back end: matrix store, cofactor/determinant sequencer and result emission.
module mi4_back #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF,
	parameter int NUMW = mi4_pkg::CW + 2 * FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  mi4_pkg::q_head_t head,
	output logic pop,
	output mi4_pkg::div_req_t div_req,
	output logic [NUMW-1:0] div_num,
	output logic [mi4_pkg::DW-1:0] div_den,
	input  mi4_pkg::div_res_t div_res,
	output logic strobe,
	output logic [3:0] out_index,
	output logic signed [31:0] out_value,
	output logic singular,
	output logic saturated,
	output logic last_result
);
	import mi4_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_COF_RD, S_COF_MUL, S_COF_ACC, S_DET_RD, S_DET_MUL, S_DET_ACC,
		S_OUT, S_SING_RD, S_SING_EMIT, S_DIV_START, S_DIV_WAIT
	} state_t;

	state_t state_q;
	logic [3:0] k_q;
	logic [1:0] term_q, op_q;

	logic [31:0] mem_q [16];
	logic [31:0] rda_q, rdb_q;
	logic signed [CW-1:0] cof_q [16];
	logic signed [65:0] prod_q, dreg_q;
	logic signed [DW-1:0] acc_q;

	pair_t pair;
	logic [3:0] addr_a, cof_sel;
	logic signed [32:0] ma, mb;
	logic signed [CW-1:0] cof_rd;
	logic signed [CEXT-1:0] cof_x;
	logic [31:0] chunk;
	logic signed [DW-1:0] pe, addend, acc_nx;
	logic term_neg, det_zero;
	logic [CW-1:0] cof_abs;

	assign pop = (state_q == S_IDLE) && head.valid;
	assign pair = cof_pair(k_q, term_q, op_q);
	assign term_neg = (term_q == 2'd1) ^ k_q[0] ^ k_q[2];
	assign det_zero = (acc_q == '0);

	always_comb begin
		unique case (state_q)
			S_COF_RD: addr_a = pair.a;
			S_DET_RD: addr_a = {2'b00, k_q[1:0]};
			default:  addr_a = k_q;
		endcase
	end

	// cofactor file read: column-0 cofactors during the determinant, else k
	assign cof_sel = (state_q == S_DET_MUL) ? {k_q[1:0], 2'b00} : k_q;
	assign cof_rd = cof_q[cof_sel];
	assign cof_x = CEXT'(cof_rd);
	assign chunk = cof_x[32 * op_q +: 32];

	assign ma = {rda_q[31], rda_q};
	always_comb begin
		if (state_q == S_DET_MUL) begin
			mb = (op_q == 2'd3) ? {chunk[31], chunk} : {1'b0, chunk};
		end else begin
			unique case (op_q)
				2'd0, 2'd1: mb = {rdb_q[31], rdb_q};
				2'd2:       mb = {1'b0, dreg_q[31:0]};
				default:    mb = dreg_q[64:32];
			endcase
		end
	end

	// accumulate step: shift the product into place and add with its sign
	assign pe = DW'(prod_q);
	always_comb begin
		if (state_q == S_DET_ACC) begin
			addend = pe << (32 * op_q);
		end else begin
			addend = (op_q == 2'd3) ? (pe << 32) : pe;
			if (term_neg) addend = -addend;
		end
	end
	assign acc_nx = acc_q + addend;

	// divider operands
	assign cof_abs = cof_rd[CW-1] ? CW'(-cof_rd) : CW'(cof_rd);
	assign div_num = NUMW'(cof_abs) << (2 * FRAC_BITS);
	assign div_den = acc_q[DW-1] ? DW'(-acc_q) : DW'(acc_q);
	assign div_req.start = (state_q == S_DIV_START);
	assign div_req.neg = cof_rd[CW-1] ^ acc_q[DW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= 4'd0;
			term_q <= 2'd0;
			op_q <= 2'd0;
			strobe <= 1'b0;
			out_index <= 4'd0;
			out_value <= '0;
			singular <= 1'b0;
			saturated <= 1'b0;
			last_result <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					k_q <= 4'd0;
					term_q <= 2'd0;
					op_q <= 2'd0;
					if (head.valid && head.item.last) state_q <= S_COF_RD;
				end
				S_COF_RD:  state_q <= S_COF_MUL;
				S_COF_MUL: state_q <= S_COF_ACC;
				S_COF_ACC: begin
					op_q <= op_q + 2'd1;
					state_q <= S_COF_RD;
					if (op_q == 2'd3) begin
						term_q <= (term_q == 2'd2) ? 2'd0 : term_q + 2'd1;
						if (term_q == 2'd2) begin
							k_q <= k_q + 4'd1;
							if (k_q == LAST_IDX) state_q <= S_DET_RD;
						end
					end
				end
				S_DET_RD:  state_q <= S_DET_MUL;
				S_DET_MUL: state_q <= S_DET_ACC;
				S_DET_ACC: begin
					op_q <= op_q + 2'd1;
					state_q <= S_DET_RD;
					if (op_q == 2'd3) begin
						if (k_q == 4'd3) begin
							k_q <= 4'd0;
							state_q <= S_OUT;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end
				end
				S_OUT: state_q <= det_zero ? S_SING_RD : S_DIV_START;
				S_SING_RD: state_q <= S_SING_EMIT;
				S_SING_EMIT: begin
					strobe <= 1'b1;
					out_index <= k_q;
					out_value <= rda_q;
					singular <= 1'b1;
					saturated <= 1'b0;
					last_result <= (k_q == LAST_IDX);
					k_q <= k_q + 4'd1;
					state_q <= (k_q == LAST_IDX) ? S_IDLE : S_SING_RD;
				end
				S_DIV_START: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_res.done) begin
						strobe <= 1'b1;
						out_index <= k_q;
						out_value <= div_res.value;
						singular <= 1'b0;
						saturated <= div_res.sat;
						last_result <= (k_q == LAST_IDX);
						k_q <= k_q + 4'd1;
						state_q <= (k_q == LAST_IDX) ? S_IDLE : S_DIV_START;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (pop) mem_q[head.item.idx] <= head.item.val;
		rda_q <= mem_q[addr_a];
		rdb_q <= mem_q[pair.b];
	end

	// datapath: shared 33x33 multiplier, difference register, accumulator
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		unique case (state_q)
			S_IDLE: acc_q <= '0;
			S_COF_ACC: begin
				unique case (op_q)
					2'd0: dreg_q <= prod_q;
					2'd1: dreg_q <= dreg_q - prod_q;
					default: begin
						if (op_q == 2'd3 && term_q == 2'd2) begin
							cof_q[k_q] <= acc_nx[CW-1:0];
							acc_q <= '0;
						end else begin
							acc_q <= acc_nx;
						end
					end
				endcase
			end
			S_DET_ACC: acc_q <= acc_nx;
			default: ;
		endcase
	end

endmodule

// File: rtl/matrix4_inverse_cofactor_top.sv
// 4x4 fixed-point matrix inverse by adjugate: loads elements, then emits 16 results.
// A plain element is written into the store when the idle back end pops it. A last element starts
// cofactor and determinant work on one shared 33x33 multiplier, each micro-op passing read,
// multiply and accumulate states, then 16 results from the bit-serial divider (cut short when the
// quotient overflows 32 bits), or the stored elements echoed when singular. Throughput: one item a cycle into a
// 2-deep queue; busy while full. Results cannot be stalled. Reset: async, clears control.
module matrix4_inverse_cofactor_top #(
	parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [3:0] element_index,
	input  logic signed [31:0] element_value,
	input  logic last_element,
	output logic strobe,
	output logic [3:0] out_index,
	output logic signed [31:0] out_value,
	output logic singular,
	output logic saturated,
	output logic last_result
);
	import mi4_pkg::*;

	`include "assert_macros.svh"

	localparam int NUMW = CW + 2 * FRAC_BITS;

	item_t in_item;
	q_head_t head;
	logic pop;
	div_req_t div_req;
	div_res_t div_res;
	logic [NUMW-1:0] div_num;
	logic [DW-1:0] div_den;

	// one item: column-major index, Q-format element, last flag
	assign in_item.idx = element_index;
	assign in_item.val = element_value;
	assign in_item.last = last_element;

	// front: item queue, so the store write and inversion start run decoupled
	mi4_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.pop(pop), .busy(busy), .head(head)
	);

	// back: store, cofactor sequencer, determinant, result emission
	mi4_back #(.FRAC_BITS(FRAC_BITS), .NUMW(NUMW)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .pop(pop),
		.div_req(div_req), .div_num(div_num), .div_den(div_den), .div_res(div_res),
		.strobe(strobe), .out_index(out_index), .out_value(out_value),
		.singular(singular), .saturated(saturated), .last_result(last_result)
	);

	// divider: |cofactor| * 2^(2F) / |det|, saturated to 32 bits
	mi4_div #(.FRAC_BITS(FRAC_BITS), .NUMW(NUMW)) u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .num(div_num), .den(div_den),
		.res(div_res)
	);

	// last result always carries the final index
	`ASSERT_IMP(a_last_idx, clk, arst_n, strobe && last_result, out_index == LAST_IDX, "last result not at final index")
	// a singular echo is never flagged as clamped
	`ASSERT_IMP(a_sing_nosat, clk, arst_n, strobe && singular, !saturated, "singular result flagged saturated")
	// the queue only fills on an accepted item
	`ASSERT_IMP(a_busy_rise, clk, arst_n, $rose(busy), $past(start), "busy rose without an item")

endmodule

// File: dv/tb_matrix4_inverse_cofactor_top.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse block.
module tb_matrix4_inverse_cofactor_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mi4_pkg::*;

	localparam int FB = 16;

	// One load item as the driver sees it
	typedef struct {
		logic [3:0] idx;
		logic signed [31:0] val;
		logic last;
	} load_t;

	// One inverse element as the monitor sees it
	typedef struct {
		logic [3:0] idx;
		logic [31:0] val;
		logic sing;
		logic sat;
		logic lst;
	} inv_elem_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [3:0] element_index;
	logic signed [31:0] element_value;
	logic last_element;
	logic strobe;
	logic [3:0] out_index;
	logic signed [31:0] out_value;
	logic singular;
	logic saturated;
	logic last_result;

	matrix4_inverse_cofactor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.element_index(element_index),
		.element_value(element_value),
		.last_element(last_element),
		.strobe(strobe),
		.out_index(out_index),
		.out_value(out_value),
		.singular(singular),
		.saturated(saturated),
		.last_result(last_result)
	);

	load_t load_q[$];        // items waiting for the driver
	inv_elem_t inverse_q[$]; // predicted results, oldest first
	logic signed [31:0] shadow_store[16];
	int errors = 0;
	int n_matrices = 0;
	int n_singular = 0;
	int n_sat = 0;
	int n_results = 0;
	int n_pushed = 0;
	int n_accepted = 0;
	bit quiet = 0;           // no idling in the final stretch
	int gap_left = 0;
	logic accepted;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Signed cofactor of element k = g + 4*r: minor without group g and residue r.
	// 32x32 products fit 64 bits, triple products fit 97; 128 bits is exact.
	function automatic logic signed [127:0] cofactor_of(input int k);
		int g, r, n;
		int gs[3], rs[3];
		int qa[3], sa[3];
		logic signed [127:0] acc, a, b, c, d, o, term;
		g = k % 4;
		r = k / 4;
		qa = '{1, 0, 0};
		sa = '{2, 2, 1};
		n = 0;
		for (int i = 0; i < 4; i++) if (i != g) begin gs[n] = i; n++; end
		n = 0;
		for (int i = 0; i < 4; i++) if (i != r) begin rs[n] = i; n++; end
		acc = 0;
		for (int p = 0; p < 3; p++) begin
			a = shadow_store[gs[1] * 4 + rs[qa[p]]];
			b = shadow_store[gs[2] * 4 + rs[sa[p]]];
			c = shadow_store[gs[1] * 4 + rs[sa[p]]];
			d = shadow_store[gs[2] * 4 + rs[qa[p]]];
			o = shadow_store[gs[0] * 4 + rs[p]];
			term = o * (a * b - c * d);
			if (p == 1) acc = acc - term;
			else acc = acc + term;
		end
		if ((g + r) % 2 == 1) acc = -acc;
		return acc;
	endfunction

	// Store the element; on a last item push the 16 expected inverse elements
	task automatic predict_inverse(input load_t it);
		logic signed [127:0] cof[16];
		logic signed [255:0] det, num, q;
		logic [255:0] mag_n, mag_d, mag_q;
		inv_elem_t e;
		bit neg;
		shadow_store[it.idx] = it.val;
		if (!it.last) return;
		n_matrices++;
		for (int k = 0; k < 16; k++) cof[k] = cofactor_of(k);
		det = 0;
		for (int k = 0; k < 4; k++)
			det = det + $signed(shadow_store[k]) * cof[k * 4];
		if (det == 0) n_singular++;
		for (int k = 0; k < 16; k++) begin
			e.idx = k[3:0];
			e.lst = (k == 15);
			if (det == 0) begin
				e.val = shadow_store[k];
				e.sing = 1;
				e.sat = 0;
			end else begin
				num = cof[k];
				neg = (num < 0) != (det < 0);
				mag_n = (num < 0) ? -num : num;
				mag_n = mag_n << (2 * FB);
				mag_d = (det < 0) ? -det : det;
				mag_q = mag_n / mag_d;
				e.sing = 0;
				if (!neg && mag_q > 256'h7FFF_FFFF) begin
					e.val = 32'h7FFF_FFFF;
					e.sat = 1;
				end else if (neg && mag_q > 256'h8000_0000) begin
					e.val = 32'h8000_0000;
					e.sat = 1;
				end else begin
					q = neg ? -mag_q : mag_q;
					e.val = q[31:0];
					e.sat = 0;
				end
				if (e.sat) n_sat++;
			end
			inverse_q.push_back(e);
		end
	endtask

	function automatic logic [31:0] rand_elem(input int mode);
		case (mode)
			0: return $urandom();                              // full range
			1: return $signed($urandom_range(0, 8)) - 4 <<< 16; // small integers
			2: return $urandom_range(0, 3) == 0 ? 32'h0 : 32'h0001_0000;
			default: return $signed($urandom_range(0, 2047)) - 1024;
		endcase
	endfunction

	task automatic push_load(input int idx, input logic [31:0] v, input bit lst);
		load_t it;
		it.idx = idx[3:0];
		it.val = v;
		it.last = lst;
		load_q.push_back(it);
		n_pushed++;
	endtask

	// Full matrix in a random order, last on the final element
	task automatic push_matrix(input int mode);
		int ord[16];
		int j, t;
		for (int i = 0; i < 16; i++) ord[i] = i;
		for (int i = 15; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = ord[i]; ord[i] = ord[j]; ord[j] = t;
		end
		for (int i = 0; i < 16; i++) push_load(ord[i], rand_elem(mode), i == 15);
	endtask

	// Driver: changes inputs on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 0;
		end else begin
			if (!start || accepted) begin
				if (!quiet && gap_left == 0 && $urandom_range(0, 9) == 0)
					gap_left = $urandom_range(1, 7);
				if (gap_left > 0 || load_q.size() == 0) begin
					if (gap_left > 0) gap_left--;
					start <= 0;
				end else begin
					load_t it;
					it = load_q.pop_front();
					element_index <= it.idx;
					element_value <= it.val;
					last_element <= it.last;
					start <= 1;
				end
			end
		end
	end

	// Acceptance seen at the rising edge feeds the predictor
	initial begin
		accepted = 0;
	end
	always @(posedge clk) begin
		accepted = 0;
		if (arst_n && start && !busy) begin
			load_t it;
			it.idx = element_index;
			it.val = element_value;
			it.last = last_element;
			predict_inverse(it);
			accepted = 1;
			n_accepted++;
		end
	end

	// Monitor: compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			inv_elem_t e;
			n_results++;
			if (inverse_q.size() == 0) begin
				$display("%0t: unexpected result idx=%0d val=%h", $time, out_index, out_value);
				errors++;
			end else begin
				e = inverse_q.pop_front();
				if (out_index !== e.idx || out_value !== e.val || singular !== e.sing ||
					saturated !== e.sat || last_result !== e.lst) begin
					$display("%0t: mismatch exp idx=%0d val=%h sing=%b sat=%b last=%b",
						$time, e.idx, e.val, e.sing, e.sat, e.lst);
					$display("%0t:          act idx=%0d val=%h sing=%b sat=%b last=%b",
						$time, out_index, out_value, singular, saturated, last_result);
					errors++;
				end
			end
		end
	end

	initial begin
		int total;
		start = 0;
		element_index = 0;
		element_value = 0;
		last_element = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Identity matrix: inverse is identity
		for (int i = 0; i < 16; i++)
			push_load(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0, i == 15);
		// Scale the diagonal to 1/256 -> inverse diagonal of 256; store kept between runs
		push_load(0, 32'h0000_0100, 0);
		push_load(5, 32'h0000_0100, 0);
		push_load(10, 32'h0000_0100, 0);
		push_load(15, 32'h0000_0100, 1);
		// Negate the first diagonal element to -1/256: its inverse entry is -256
		push_load(0, 32'hFFFF_FF00, 0);
		push_load(5, 32'h0000_0100, 1);
		// Zero a row -> singular echo
		push_load(0, 32'h0, 1);
		// Extremes of the value field, including both signs
		push_load(0, 32'h8000_0000, 0);
		push_load(5, 32'h7FFF_FFFF, 0);
		push_load(10, 32'hFFFF_FFFF, 1);
		push_load(15, 32'h8000_0000, 1);

		// Random part: mostly full matrices, plus single-entry updates with a random last flag
		total = 27;
		while (total < 238) begin
			if ($urandom_range(0, 3) == 0) begin
				push_load($urandom_range(0, 15), rand_elem($urandom_range(0, 3)),
					$urandom_range(0, 1));
				total++;
			end else begin
				push_matrix($urandom_range(0, 3));
				total += 16;
			end
		end
		// Final stretch without idling
		wait (load_q.size() == 0);
		quiet = 1;
		push_matrix(1);
		push_matrix(0);

		wait (n_accepted == n_pushed && inverse_q.size() == 0);
		repeat (700) @(posedge clk);
		$display("Checked %0d items, %0d inversions (%0d singular), %0d results.",
			n_accepted, n_matrices, n_singular, n_results);
		$display("Saturated elements predicted: %0d.", n_sat);
		if (errors == 0 && inverse_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: covers every item being a last one, with wide margin
	initial begin
		#5000000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mi4_pkg.sv
rtl/mi4_front.sv
rtl/mi4_div.sv
rtl/mi4_back.sv
rtl/matrix4_inverse_cofactor_top.sv
dv/tb_matrix4_inverse_cofactor_top.sv
